### design/flb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flb_pkg
// Shared constants and the stage data carried down the cell chain.
// ----------------------------------------------------------------------------
package flb_pkg;

  localparam int MASK_BITS  = 128;
  localparam int SLICE_BITS = 8;
  localparam int NUM_CELLS  = MASK_BITS / SLICE_BITS;
  localparam int CNT_W      = 8;
  localparam int ION_W      = 8;
  localparam int SHIFT_W    = $clog2(2 * MASK_BITS) + 1;

  typedef logic [MASK_BITS-1:0] mask_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // Masks are consumed from the bottom, one slice per cell.
  typedef struct packed {
    mask_t b_mask;
    mask_t y_mask;
    mask_t p_mask;
    cnt_t  b_cnt;
    cnt_t  y_cnt;
    cnt_t  p_cnt;
    cnt_t  b_cur;
    cnt_t  b_best;
    cnt_t  y_cur;
    cnt_t  y_best;
  } acc_t;

endpackage
`default_nettype wire

### design/flb_align.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flb_align
// Front stage: lines the y mask up against the b mask for complementary
// ordinals and registers the masks with cleared accumulators.
// ----------------------------------------------------------------------------
module flb_align (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid_in,
  output logic              ready_in,
  input  logic              ready_next,
  output logic              valid_out,
  input  flb_pkg::mask_t    b_in,
  input  flb_pkg::mask_t    y_in,
  input  logic [flb_pkg::ION_W-1:0] ion_count,
  output flb_pkg::acc_t     acc_out
);
  import flb_pkg::*;

  mask_t                   rev_y;
  logic [SHIFT_W-1:0]      shamt;
  logic [2*MASK_BITS-1:0]  wide;
  acc_t                    acc_next;

  // aligned[i] = y[n-1-i]; a shift of the full width (n = 0) clears everything
  always_comb begin
    for (int i = 0; i < MASK_BITS; i++) begin
      rev_y[i] = y_in[MASK_BITS-1-i];
    end
    shamt = SHIFT_W'(2 * MASK_BITS) - SHIFT_W'(ion_count);
    wide  = {rev_y, {MASK_BITS{1'b0}}} >> shamt;
  end

  always_comb begin
    acc_next        = '0;
    acc_next.b_mask = b_in;
    acc_next.y_mask = y_in;
    acc_next.p_mask = b_in & wide[MASK_BITS-1:0];
  end

  assign ready_in = !valid_out || ready_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (ready_in) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      acc_out <= acc_next;
    end
  end

endmodule
`default_nettype wire

### design/flb_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flb_cell
// One cell of the chain: folds the bottom slice of each mask into the
// counts and run trackers, then hands the shifted masks on.
// ----------------------------------------------------------------------------
module flb_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid_in,
  output logic          ready_in,
  input  logic          ready_next,
  output logic          valid_out,
  input  flb_pkg::acc_t acc_in,
  output flb_pkg::acc_t acc_out
);
  import flb_pkg::*;

  acc_t acc_next;

  always_comb begin
    acc_next = acc_in;
    for (int j = 0; j < SLICE_BITS; j++) begin
      acc_next.b_cnt = acc_next.b_cnt + CNT_W'(acc_in.b_mask[j]);
      acc_next.y_cnt = acc_next.y_cnt + CNT_W'(acc_in.y_mask[j]);
      acc_next.p_cnt = acc_next.p_cnt + CNT_W'(acc_in.p_mask[j]);
      // runs carry across slice edges through the cur fields
      if (acc_in.b_mask[j]) begin
        acc_next.b_cur = acc_next.b_cur + CNT_W'(1);
        if (acc_next.b_cur > acc_next.b_best) begin
          acc_next.b_best = acc_next.b_cur;
        end
      end else begin
        acc_next.b_cur = '0;
      end
      if (acc_in.y_mask[j]) begin
        acc_next.y_cur = acc_next.y_cur + CNT_W'(1);
        if (acc_next.y_cur > acc_next.y_best) begin
          acc_next.y_best = acc_next.y_cur;
        end
      end else begin
        acc_next.y_cur = '0;
      end
    end
    acc_next.b_mask = acc_in.b_mask >> SLICE_BITS;
    acc_next.y_mask = acc_in.y_mask >> SLICE_BITS;
    acc_next.p_mask = acc_in.p_mask >> SLICE_BITS;
  end

  assign ready_in = !valid_out || ready_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (ready_in) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      acc_out <= acc_next;
    end
  end

endmodule
`default_nettype wire

### design/fragment_ladder_bit_features.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fragment_ladder_bit_features
// Population counts, longest runs and complementary pair count of b/y
// fragment match masks.
// ----------------------------------------------------------------------------
// One transaction is accepted every cycle unless in_stall is high, and it passes
// through one alignment stage that lines the y mask up with the b mask by the
// ion count, then a chain of 16 cells that each fold 8 mask bits into the
// counts and run trackers. Every stage holds its own transaction, so bubbles
// close up and new transactions are still taken while a finished result is
// stalled at the output, until the whole chain is full.
// ----------------------------------------------------------------------------
module fragment_ladder_bit_features (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] b_bits_0,
  input  logic [31:0] b_bits_1,
  input  logic [31:0] b_bits_2,
  input  logic [31:0] b_bits_3,
  input  logic [31:0] y_bits_0,
  input  logic [31:0] y_bits_1,
  input  logic [31:0] y_bits_2,
  input  logic [31:0] y_bits_3,
  input  logic [7:0]  y_ion_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  b_match_count,
  output logic [7:0]  y_match_count,
  output logic [7:0]  b_longest_run,
  output logic [7:0]  y_longest_run,
  output logic [7:0]  pair_count
);
  import flb_pkg::*;

  acc_t  chain   [NUM_CELLS+1];
  logic  valid_c [NUM_CELLS+1];
  logic  ready_c [NUM_CELLS+1];
  logic  ready_front;

  flb_align u_align (
    .clk        (clk),
    .rst        (rst),
    .valid_in   (in_valid),
    .ready_in   (ready_front),
    .ready_next (ready_c[0]),
    .valid_out  (valid_c[0]),
    .b_in       ({b_bits_3, b_bits_2, b_bits_1, b_bits_0}),
    .y_in       ({y_bits_3, y_bits_2, y_bits_1, y_bits_0}),
    .ion_count  (y_ion_count),
    .acc_out    (chain[0])
  );

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    flb_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .valid_in   (valid_c[k]),
      .ready_in   (ready_c[k]),
      .ready_next (ready_c[k+1]),
      .valid_out  (valid_c[k+1]),
      .acc_in     (chain[k]),
      .acc_out    (chain[k+1])
    );
  end

  assign ready_c[NUM_CELLS] = !out_stall;
  assign in_stall           = !ready_front;

  assign out_valid     = valid_c[NUM_CELLS];
  assign b_match_count = chain[NUM_CELLS].b_cnt;
  assign y_match_count = chain[NUM_CELLS].y_cnt;
  assign b_longest_run = chain[NUM_CELLS].b_best;
  assign y_longest_run = chain[NUM_CELLS].y_best;
  assign pair_count    = chain[NUM_CELLS].p_cnt;

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> valid_c[0])
    else $error("accepted transaction did not enter the alignment stage");

  a_run_le_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (b_longest_run <= b_match_count) && (y_longest_run <= y_match_count))
    else $error("longest run exceeds population count");

  a_pair_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pair_count <= b_match_count) && (pair_count <= y_match_count))
    else $error("pair count exceeds a mask population count");
`endif

endmodule
`default_nettype wire
